@@ src/vat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vat_pkg: shared types and constants of the vertex activity rate tracker
// Word layouts, opcode and state codes, register indexes and the fixed
// widths of the rate arithmetic.
// ============================================================================
package vat_pkg;

    localparam int VERTEX_W    = 10;
    localparam int KEEP_W      = 16;
    localparam int ACTIVE_W    = 11;
    localparam int RATE_W      = 32;
    localparam int FRAC_W      = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    // Operand and product widths of the shared multiplier.
    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = 51;

    localparam logic [CFG_INDEX_W-1:0] CFG_VELOCITY_KEEP   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACCEL_KEEP      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_VERTICES = 2'd2;

    localparam logic [KEEP_W-1:0]   RESET_KEEP   = 16'd21823;
    localparam logic [ACTIVE_W-1:0] RESET_ACTIVE = 11'd1024;

    // Q2.16 value of one, as a multiplier operand.
    localparam logic [MUL_A_W-1:0] ONE_Q16 = 18'h10000;

    // Steps of the per-vertex rate update.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_KA_ACC = 3'd0;
    localparam logic [STEP_W-1:0] STEP_FA_VEL = 3'd1;
    localparam logic [STEP_W-1:0] STEP_FA_CNT = 3'd2;
    localparam logic [STEP_W-1:0] STEP_KV_VEL = 3'd3;
    localparam logic [STEP_W-1:0] STEP_FV_CNT = 3'd4;
    localparam logic [STEP_W-1:0] STEP_V_SUM  = 3'd5;

    typedef enum logic [1:0] {
        OP_EDGE  = 2'd0,
        OP_CLOSE = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_E_SRC,
        BK_E_DST,
        BK_R_WAIT,
        BK_S_READ,
        BK_S_LOAD,
        BK_S_MUL,
        BK_S_WRITE,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [VERTEX_W-1:0] source_vertex;
        logic [VERTEX_W-1:0] dest_vertex;
    } in_item_t;

    typedef struct packed {
        logic [VERTEX_W-1:0]      vertex_index;
        logic [RATE_W-1:0]        velocity;
        logic signed [RATE_W-1:0] acceleration;
        logic                     read_valid;
    } out_item_t;

    typedef struct packed {
        logic [KEEP_W-1:0]   velocity_keep;
        logic [KEEP_W-1:0]   acceleration_keep;
        logic [ACTIVE_W-1:0] active_vertices;
    } cfg_t;

    typedef struct packed {
        op_t                 op;
        logic [VERTEX_W-1:0] src;
        logic [VERTEX_W-1:0] dst;
        logic                src_ok;
        logic                dst_ok;
    } cmd_t;

endpackage
`default_nettype wire

@@ src/vat_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vat_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; read data is registered and returns the
// old contents when the same entry is written in that cycle.
// ============================================================================
module vat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ src/vat_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vat_fifo: small register queue
// Power-of-two depth, push and pop in the same cycle allowed.
// ============================================================================
module vat_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    localparam int PW = $clog2(DEPTH);

    logic [WIDTH-1:0] entries_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == (PW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule
`default_nettype wire

@@ src/vat_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vat_front: input side of the tracker
// Decodes each incoming word, checks its vertices against the store size
// and queues the resulting command for the back end.
// ============================================================================
module vat_front #(
    parameter int NUM_VERTICES = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire vat_pkg::in_item_t item,
    input  wire logic              hold,
    output logic                   full,
    output logic                   cmd_valid,
    output vat_pkg::cmd_t          cmd,
    input  wire logic              cmd_pop
);

    localparam int AW = $clog2(NUM_VERTICES);
    localparam int XW = ((AW > vat_pkg::VERTEX_W) ? AW : vat_pkg::VERTEX_W) + 1;

    vat_pkg::cmd_t cmd_in;
    logic          q_full;
    logic          q_empty;

    always_comb
    begin
        cmd_in.op     = vat_pkg::op_t'(item.opcode);
        cmd_in.src    = item.source_vertex;
        cmd_in.dst    = item.dest_vertex;
        cmd_in.src_ok = (XW'(item.source_vertex) < XW'(NUM_VERTICES));
        cmd_in.dst_ok = (XW'(item.dest_vertex) < XW'(NUM_VERTICES));
    end

    // Input is held off while the stores are being cleared after reset.
    assign full      = q_full | hold;
    assign cmd_valid = ~q_empty;

    vat_fifo #(
        .WIDTH ($bits(vat_pkg::cmd_t)),
        .DEPTH (2)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push & ~full),
        .wdata (cmd_in),
        .full  (q_full),
        .pop   (cmd_pop),
        .rdata (cmd),
        .empty (q_empty)
    );

endmodule
`default_nettype wire

@@ src/vat_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vat_back: command executor of the tracker
// Owns the three vertex stores, runs edge counting, reads and the batch-close
// sweep with one shared multiplier, and produces one result per command.
// ============================================================================
module vat_back #(
    parameter int NUM_VERTICES = 1024,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire vat_pkg::cfg_t cfg,
    input  wire logic          cmd_valid,
    input  wire vat_pkg::cmd_t cmd,
    output logic               cmd_pop,
    input  wire logic          res_full,
    output logic               res_push,
    output vat_pkg::out_item_t res,
    output logic               clearing
);

    localparam int AW = $clog2(NUM_VERTICES);
    localparam int CW = ((AW > vat_pkg::ACTIVE_W) ? AW : vat_pkg::ACTIVE_W) + 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(NUM_VERTICES - 1);
    localparam int PW = vat_pkg::PROD_W;
    localparam int RW = vat_pkg::RATE_W;

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        logic [COUNT_WIDTH-1:0] r;
        if (&v)
        begin
            r = v;
        end
        else
        begin
            r = v + 1'b1;
        end
        return r;
    endfunction

    vat_pkg::back_state_t state_reg, state_next;
    vat_pkg::cmd_t        cur_reg, cur_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [vat_pkg::STEP_W-1:0] step_reg, step_next;

    logic [COUNT_WIDTH-1:0] wval_reg, wval_next;
    logic [COUNT_WIDTH-1:0] c_reg, c_next;
    logic [RW-1:0]          vel_reg, vel_next;
    logic signed [RW-1:0]   acc_reg, acc_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic signed [PW-1:0]   asum_reg, asum_next;
    logic signed [PW-1:0]   vsum_reg, vsum_next;
    logic [RW-1:0]          res_vel_reg, res_vel_next;
    logic [RW-1:0]          res_acc_reg, res_acc_next;

    logic                   cnt_we, rate_we;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata, cnt_base;
    logic [RW-1:0]          vel_wdata, vel_rdata;
    logic [RW-1:0]          acc_wdata, acc_rdata;

    logic signed [vat_pkg::MUL_A_W-1:0] ka, fa, kv, fv, mul_a;
    logic signed [vat_pkg::MUL_B_W-1:0] acc_b, vel_b, cnt_b, mul_b;
    logic [RW-1:0]          acc_sat, vel_sat;
    logic                   last_idx, in_active, idle_take;

    assign clearing  = (state_reg == vat_pkg::BK_CLEAR);
    assign last_idx  = (idx_reg == LAST_IDX);
    assign in_active = (CW'(idx_reg) < CW'(cfg.active_vertices));
    assign idle_take = cmd_valid & ~res_full;

    // Multiplier operands; fraction weights are one minus the keep factors.
    assign ka    = vat_pkg::MUL_A_W'(cfg.acceleration_keep);
    assign kv    = vat_pkg::MUL_A_W'(cfg.velocity_keep);
    assign fa    = vat_pkg::ONE_Q16 - vat_pkg::MUL_A_W'(cfg.acceleration_keep);
    assign fv    = vat_pkg::ONE_Q16 - vat_pkg::MUL_A_W'(cfg.velocity_keep);
    assign acc_b = {acc_reg[RW-1], acc_reg};
    assign vel_b = {1'b0, vel_reg};
    assign cnt_b = vat_pkg::MUL_B_W'(c_reg);

    always_comb
    begin
        case (step_reg)
            vat_pkg::STEP_KA_ACC:
            begin
                mul_a = ka;
                mul_b = acc_b;
            end
            vat_pkg::STEP_FA_VEL:
            begin
                mul_a = fa;
                mul_b = vel_b;
            end
            vat_pkg::STEP_FA_CNT:
            begin
                mul_a = fa;
                mul_b = cnt_b;
            end
            vat_pkg::STEP_KV_VEL:
            begin
                mul_a = kv;
                mul_b = vel_b;
            end
            default:
            begin
                mul_a = fv;
                mul_b = cnt_b;
            end
        endcase
    end

    // Saturation of the finished sums to their 32-bit stored ranges.
    always_comb
    begin
        if (&asum_reg[PW-1:RW-1] || ~|asum_reg[PW-1:RW-1])
        begin
            acc_sat = asum_reg[RW-1:0];
        end
        else if (asum_reg[PW-1])
        begin
            acc_sat = {1'b1, {(RW-1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(RW-1){1'b1}}};
        end
        vel_sat = (|vsum_reg[PW-1:RW]) ? {RW{1'b1}} : vsum_reg[RW-1:0];
    end

    // A self loop reads its count before the first increment lands.
    assign cnt_base = (cur_reg.src_ok && (cur_reg.dst == cur_reg.src)) ? wval_reg : cnt_rdata;

    always_comb
    begin
        case (state_reg)
            vat_pkg::BK_IDLE:  mem_raddr = AW'(cmd.src);
            vat_pkg::BK_E_SRC: mem_raddr = AW'(cur_reg.dst);
            default:           mem_raddr = idx_reg;
        endcase
        case (state_reg)
            vat_pkg::BK_E_SRC: mem_waddr = AW'(cur_reg.src);
            vat_pkg::BK_E_DST: mem_waddr = AW'(cur_reg.dst);
            default:           mem_waddr = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vat_pkg::BK_CLEAR:
            begin
                if (last_idx)
                begin
                    state_next = vat_pkg::BK_IDLE;
                end
            end
            vat_pkg::BK_IDLE:
            begin
                if (idle_take)
                begin
                    case (cmd.op)
                        vat_pkg::OP_EDGE:  state_next = vat_pkg::BK_E_SRC;
                        vat_pkg::OP_CLOSE: state_next = vat_pkg::BK_S_READ;
                        vat_pkg::OP_READ:  state_next = vat_pkg::BK_R_WAIT;
                        default:           state_next = vat_pkg::BK_DONE;
                    endcase
                end
            end
            vat_pkg::BK_E_SRC:  state_next = vat_pkg::BK_E_DST;
            vat_pkg::BK_E_DST:  state_next = vat_pkg::BK_DONE;
            vat_pkg::BK_R_WAIT: state_next = vat_pkg::BK_DONE;
            vat_pkg::BK_S_READ:
            begin
                if (in_active)
                begin
                    state_next = vat_pkg::BK_S_LOAD;
                end
                else if (last_idx)
                begin
                    state_next = vat_pkg::BK_DONE;
                end
            end
            vat_pkg::BK_S_LOAD: state_next = vat_pkg::BK_S_MUL;
            vat_pkg::BK_S_MUL:
            begin
                if (step_reg == vat_pkg::STEP_V_SUM)
                begin
                    state_next = vat_pkg::BK_S_WRITE;
                end
            end
            vat_pkg::BK_S_WRITE:
            begin
                state_next = last_idx ? vat_pkg::BK_DONE : vat_pkg::BK_S_READ;
            end
            vat_pkg::BK_DONE:   state_next = vat_pkg::BK_IDLE;
            default:            state_next = vat_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop      = 1'b0;
        res_push     = 1'b0;
        cnt_we       = 1'b0;
        rate_we      = 1'b0;
        cnt_wdata    = '0;
        vel_wdata    = '0;
        acc_wdata    = '0;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        wval_next    = wval_reg;
        c_next       = c_reg;
        vel_next     = vel_reg;
        acc_next     = acc_reg;
        prod_next    = mul_a * mul_b;
        asum_next    = asum_reg;
        vsum_next    = vsum_reg;
        res_vel_next = res_vel_reg;
        res_acc_next = res_acc_reg;
        case (state_reg)
            vat_pkg::BK_CLEAR:
            begin
                cnt_we   = 1'b1;
                rate_we  = 1'b1;
                idx_next = last_idx ? '0 : idx_reg + 1'b1;
            end
            vat_pkg::BK_IDLE:
            begin
                if (idle_take)
                begin
                    cmd_pop      = 1'b1;
                    cur_next     = cmd;
                    idx_next     = '0;
                    res_vel_next = '0;
                    res_acc_next = '0;
                end
            end
            vat_pkg::BK_E_SRC:
            begin
                cnt_we    = cur_reg.src_ok;
                cnt_wdata = sat_inc(cnt_rdata);
                wval_next = sat_inc(cnt_rdata);
            end
            vat_pkg::BK_E_DST:
            begin
                cnt_we    = cur_reg.dst_ok;
                cnt_wdata = sat_inc(cnt_base);
            end
            vat_pkg::BK_R_WAIT:
            begin
                if (cur_reg.src_ok)
                begin
                    res_vel_next = vel_rdata;
                    res_acc_next = acc_rdata;
                end
            end
            vat_pkg::BK_S_READ:
            begin
                if (!in_active)
                begin
                    cnt_we   = 1'b1;
                    idx_next = last_idx ? '0 : idx_reg + 1'b1;
                end
            end
            vat_pkg::BK_S_LOAD:
            begin
                c_next    = cnt_rdata;
                vel_next  = vel_rdata;
                acc_next  = acc_rdata;
                step_next = vat_pkg::STEP_KA_ACC;
            end
            vat_pkg::BK_S_MUL:
            begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    vat_pkg::STEP_FA_VEL: asum_next = prod_reg;
                    vat_pkg::STEP_FA_CNT: asum_next = asum_reg - prod_reg;
                    vat_pkg::STEP_KV_VEL: asum_next = (asum_reg >>> vat_pkg::FRAC_W) + prod_reg;
                    vat_pkg::STEP_FV_CNT: vsum_next = prod_reg >>> vat_pkg::FRAC_W;
                    vat_pkg::STEP_V_SUM:  vsum_next = vsum_reg + prod_reg;
                    default:              asum_next = asum_reg;
                endcase
            end
            vat_pkg::BK_S_WRITE:
            begin
                cnt_we    = 1'b1;
                rate_we   = 1'b1;
                vel_wdata = vel_sat;
                acc_wdata = acc_sat;
                idx_next  = last_idx ? '0 : idx_reg + 1'b1;
            end
            vat_pkg::BK_DONE:
            begin
                res_push = 1'b1;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        res.vertex_index = (cur_reg.op == vat_pkg::OP_READ) ? cur_reg.src : '0;
        res.velocity     = res_vel_reg;
        res.acceleration = res_acc_reg;
        res.read_valid   = (cur_reg.op == vat_pkg::OP_READ);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= vat_pkg::BK_CLEAR;
            idx_reg   <= '0;
            step_reg  <= vat_pkg::STEP_KA_ACC;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        wval_reg    <= wval_next;
        c_reg       <= c_next;
        vel_reg     <= vel_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        asum_reg    <= asum_next;
        vsum_reg    <= vsum_next;
        res_vel_reg <= res_vel_next;
        res_acc_reg <= res_acc_next;
    end

    vat_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_VERTICES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (mem_waddr),
        .wdata (cnt_wdata),
        .raddr (mem_raddr),
        .rdata (cnt_rdata)
    );

    vat_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_VERTICES)
    ) u_vel_ram (
        .clk   (clk),
        .we    (rate_we),
        .waddr (mem_waddr),
        .wdata (vel_wdata),
        .raddr (mem_raddr),
        .rdata (vel_rdata)
    );

    vat_ram #(
        .WIDTH (RW),
        .DEPTH (NUM_VERTICES)
    ) u_acc_ram (
        .clk   (clk),
        .we    (rate_we),
        .waddr (mem_waddr),
        .wdata (acc_wdata),
        .raddr (mem_raddr),
        .rdata (acc_rdata)
    );

endmodule
`default_nettype wire

@@ src/vertex_activity_rate_tracker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// vertex_activity_rate_tracker: per-vertex edge activity velocity/acceleration
// Counts edge touches per vertex in a batch and, at batch close, folds the
// counts into smoothed Q16.16 velocity and acceleration stores.
// ============================================================================
//
//  Channel   Handshake                 Word            Direction
//  -------   -----------------------   -------------   ---------
//  input     push / full               item            in
//  result    pop / empty               result          out
//  config    wr_en (no wait)           wr_index/data   in
//
// Every input word yields exactly one result word, in order. In the back
// end an edge word passes through E_SRC, E_DST and DONE, a read through
// R_WAIT and DONE, and an unused opcode straight to DONE. A batch close
// sweeps the stores with the single shared multiplier (six steps per swept
// vertex) and the one read port of each store. After reset a clearing pass
// zeroes all three stores while full stays high. A two-word command queue
// and a two-word result queue let the input and result sides stall
// independently of the back end.
//
// Opcodes: edge touch bumps the source and destination counts (saturating);
// close batch sweeps the stores; read vertex returns one vertex's rates.
// Vertices outside the stores are ignored by edges and read back as zero.
// ============================================================================
module vertex_activity_rate_tracker #(
    parameter int NUM_VERTICES = 1024,
    parameter int COUNT_WIDTH  = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    input  wire vat_pkg::in_item_t                   item,
    output logic                                     full,
    input  wire logic                                pop,
    output vat_pkg::out_item_t                       result,
    output logic                                     empty,
    input  wire logic                                wr_en,
    input  wire logic [vat_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  wire logic [vat_pkg::CFG_DATA_W-1:0]      wr_data
);

    vat_pkg::cfg_t      cfg_reg, cfg_next;
    vat_pkg::cmd_t      cmd;
    vat_pkg::out_item_t res;
    logic               cmd_valid;
    logic               cmd_pop;
    logic               res_push;
    logic               res_full;
    logic               clearing;

    // Configuration registers; unknown indexes are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                vat_pkg::CFG_VELOCITY_KEEP:
                    cfg_next.velocity_keep = wr_data;
                vat_pkg::CFG_ACCEL_KEEP:
                    cfg_next.acceleration_keep = wr_data;
                vat_pkg::CFG_ACTIVE_VERTICES:
                    cfg_next.active_vertices = wr_data[vat_pkg::ACTIVE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.velocity_keep     <= vat_pkg::RESET_KEEP;
            cfg_reg.acceleration_keep <= vat_pkg::RESET_KEEP;
            cfg_reg.active_vertices   <= vat_pkg::RESET_ACTIVE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The front end decodes words and queues them; it holds off input
    // while the back end runs its post-reset clearing pass.
    vat_front #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .hold      (clearing),
        .full      (full),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // The back end only starts a command when the result queue has a free
    // slot, so its single result push can never be dropped.
    vat_back #(
        .NUM_VERTICES (NUM_VERTICES),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res),
        .clearing  (clearing)
    );

    vat_fifo #(
        .WIDTH ($bits(vat_pkg::out_item_t)),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

    a_hold_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("input open during the clearing pass");

    a_pop_has_command: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (cmd_valid && !clearing))
        else $error("command taken from an empty queue or during clearing");

endmodule
`default_nettype wire
